// ===== sv/tssw_pkg.sv =====
package tssw_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_SEND = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        ST_SEGMENT = 2'd0,
        ST_WAITING = 2'd1,
        ST_DONE    = 2'd2,
        ST_IDLE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_PACKET  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_FILE_BYTES = 3'd0,
        REG_RCV_BUFFER = 3'd1,
        REG_MSS        = 3'd2,
        REG_SSTHRESH   = 3'd3,
        REG_INIT_ACK   = 3'd4
    } reg_idx_t;

    localparam int unsigned PADDR_W = 5;

    typedef struct packed {
        logic [23:0] file_bytes;
        logic [15:0] receiver_buffer_bytes;
        logic [12:0] max_segment_bytes;
        logic [23:0] slow_start_threshold;
        logic [31:0] initial_ack_number;
    } cfg_t;

    typedef struct packed {
        logic [31:0] cwnd;
        logic [31:0] rwnd;
        logic [23:0] remaining;
        logic [23:0] round_left;
        logic [31:0] next_seq;
        logic [31:0] next_ack;
        logic [15:0] segs_sent;
        logic [15:0] acks_seen;
        phase_t      phase;
        logic        avoidance;
    } state_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [12:0] segment_bytes;
        logic        in_congestion_avoidance;
        logic [31:0] congestion_window;
        logic [31:0] receive_window;
    } result_t;

endpackage

// ===== sv/tssw_item_if.sv =====
interface tssw_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        ack_flag;
    logic [15:0] peer_buffer_used;

    modport source (output valid, mode, ack_flag, peer_buffer_used, input ready);
    modport sink (input valid, mode, ack_flag, peer_buffer_used, output ready);
endinterface

// ===== sv/tssw_result_if.sv =====
interface tssw_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        seq_number;
    logic [31:0]        ack_number;
    logic [12:0]        segment_bytes;
    logic               in_congestion_avoidance;
    logic [31:0]        congestion_window;
    logic signed [31:0] receive_window;

    modport source (
        output valid, status, seq_number, ack_number, segment_bytes,
               in_congestion_avoidance, congestion_window, receive_window,
        input  ready
    );
    modport sink (
        input  valid, status, seq_number, ack_number, segment_bytes,
               in_congestion_avoidance, congestion_window, receive_window,
        output ready
    );
endinterface

// ===== sv/tssw_step.sv =====
module tssw_step (
    input  tssw_pkg::cfg_t    cfg,
    input  tssw_pkg::state_t  cur,
    input  logic [1:0]        mode,
    input  logic              ack_flag,
    input  logic [15:0]       peer_buffer_used,
    output tssw_pkg::state_t  nxt,
    output tssw_pkg::result_t res
);

    function automatic logic rwnd_pos(logic [31:0] w);
        return (w != '0) && !w[31];
    endfunction

    function automatic tssw_pkg::state_t begin_round(tssw_pkg::state_t s);
        tssw_pkg::state_t r;
        r = s;
        if (rwnd_pos(s.rwnd) && (s.remaining != '0))
        begin
            r.round_left = (s.cwnd < {8'd0, s.remaining}) ? s.cwnd[23:0] : s.remaining;
            r.segs_sent  = '0;
            r.acks_seen  = '0;
            r.phase      = tssw_pkg::PH_SEND;
        end
        else
        begin
            r.phase = tssw_pkg::PH_DONE;
        end
        return r;
    endfunction

    logic [12:0] mss;
    logic [12:0] seg;
    logic        emitted;
    logic [32:0] cwnd_sum;
    tssw_pkg::state_t tmp;

    assign mss      = (cfg.max_segment_bytes == '0) ? 13'd1 : cfg.max_segment_bytes;
    assign cwnd_sum = {1'b0, cur.cwnd} + {20'd0, mss};

    always_comb
    begin
        tmp     = cur;
        nxt     = cur;
        seg     = '0;
        emitted = 1'b0;
        unique case (tssw_pkg::mode_t'(mode))
            tssw_pkg::MODE_START:
            begin
                tmp.cwnd      = 32'd1;
                tmp.rwnd      = {16'd0, cfg.receiver_buffer_bytes};
                tmp.next_seq  = 32'd1;
                tmp.next_ack  = cfg.initial_ack_number;
                tmp.remaining = cfg.file_bytes;
                tmp.avoidance = 1'b0;
                nxt           = begin_round(tmp);
            end
            tssw_pkg::MODE_REQUEST:
            begin
                if (cur.phase == tssw_pkg::PH_SEND)
                begin
                    seg = (cur.round_left < {11'd0, mss}) ? cur.round_left[12:0] : mss;
                    emitted        = 1'b1;
                    nxt.next_seq   = cur.next_seq + {19'd0, seg};
                    nxt.next_ack   = cur.next_ack + 32'd1;
                    nxt.remaining  = cur.remaining - {11'd0, seg};
                    nxt.round_left = cur.round_left - {11'd0, seg};
                    nxt.rwnd       = cur.rwnd - {19'd0, seg};
                    nxt.segs_sent  = cur.segs_sent + 16'd1;
                    if (!rwnd_pos(nxt.rwnd) || (nxt.round_left == '0))
                    begin
                        nxt.phase = tssw_pkg::PH_WAIT;
                    end
                end
            end
            tssw_pkg::MODE_PACKET:
            begin
                if ((cur.phase == tssw_pkg::PH_WAIT) && ack_flag)
                begin
                    tmp.rwnd      = {16'd0, cfg.receiver_buffer_bytes}
                                    - {16'd0, peer_buffer_used};
                    tmp.acks_seen = cur.acks_seen + 16'd1;
                    if (tmp.acks_seen == cur.segs_sent)
                    begin
                        if (!cur.avoidance)
                        begin
                            tmp.cwnd = cur.cwnd[31] ? '1 : {cur.cwnd[30:0], 1'b0};
                            tmp.avoidance = (tmp.cwnd >= {8'd0, cfg.slow_start_threshold});
                        end
                        else
                        begin
                            tmp.cwnd = cwnd_sum[32] ? '1 : cwnd_sum[31:0];
                        end
                        nxt = begin_round(tmp);
                    end
                    else
                    begin
                        nxt = tmp;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res.segment_bytes           = seg;
        res.in_congestion_avoidance = nxt.avoidance;
        res.congestion_window       = nxt.cwnd;
        res.receive_window          = nxt.rwnd;
        if (emitted)
        begin
            res.status     = tssw_pkg::ST_SEGMENT;
            res.seq_number = cur.next_seq;
            res.ack_number = cur.next_ack;
        end
        else if (nxt.phase == tssw_pkg::PH_IDLE)
        begin
            res.status     = tssw_pkg::ST_IDLE;
            res.seq_number = '0;
            res.ack_number = '0;
        end
        else if (nxt.phase == tssw_pkg::PH_DONE)
        begin
            res.status     = tssw_pkg::ST_DONE;
            res.seq_number = nxt.next_seq;
            res.ack_number = nxt.next_ack + 32'd1;
        end
        else
        begin
            res.status     = tssw_pkg::ST_WAITING;
            res.seq_number = nxt.next_seq;
            res.ack_number = nxt.next_ack;
        end
    end

endmodule

// ===== sv/tcp_slow_start_sender_window_core.sv =====
// The result is registered and is valid in the cycle after its item is accepted.
// One item per cycle while the sink takes results; the window state updates in a single pass
// between the state registers and the result register.
// The result register holds while the sink stalls and input is taken whenever it is free or drains.
// Reset (rst_n low, asynchronous): phase idle, window state and registers to defaults, no result.
module tcp_slow_start_sender_window_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tssw_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    tssw_item_if.sink                      item,
    tssw_result_if.source                  result
);

    tssw_pkg::cfg_t    cfg_reg;
    tssw_pkg::state_t  state_reg;
    tssw_pkg::state_t  state_next;
    tssw_pkg::result_t res_reg;
    tssw_pkg::result_t res_next;
    logic              res_valid_reg;
    logic              take;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.file_bytes            <= 24'd1;
            cfg_reg.receiver_buffer_bytes <= 16'd1;
            cfg_reg.max_segment_bytes     <= 13'd1;
            cfg_reg.slow_start_threshold  <= 24'd1;
            cfg_reg.initial_ack_number    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (tssw_pkg::reg_idx_t'(paddr[4:2]))
                tssw_pkg::REG_FILE_BYTES: cfg_reg.file_bytes            <= pwdata[23:0];
                tssw_pkg::REG_RCV_BUFFER: cfg_reg.receiver_buffer_bytes <= pwdata[15:0];
                tssw_pkg::REG_MSS:        cfg_reg.max_segment_bytes     <= pwdata[12:0];
                tssw_pkg::REG_SSTHRESH:   cfg_reg.slow_start_threshold  <= pwdata[23:0];
                tssw_pkg::REG_INIT_ACK:   cfg_reg.initial_ack_number    <= pwdata;
                default:                  cfg_reg                       <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (tssw_pkg::reg_idx_t'(paddr[4:2]))
            tssw_pkg::REG_FILE_BYTES: prdata = {8'd0, cfg_reg.file_bytes};
            tssw_pkg::REG_RCV_BUFFER: prdata = {16'd0, cfg_reg.receiver_buffer_bytes};
            tssw_pkg::REG_MSS:        prdata = {19'd0, cfg_reg.max_segment_bytes};
            tssw_pkg::REG_SSTHRESH:   prdata = {8'd0, cfg_reg.slow_start_threshold};
            tssw_pkg::REG_INIT_ACK:   prdata = cfg_reg.initial_ack_number;
            default:                  prdata = '0;
        endcase
    end

    assign item.ready = !res_valid_reg || result.ready;
    assign take       = item.valid && item.ready;

    tssw_step u_step (
        .cfg              (cfg_reg),
        .cur              (state_reg),
        .mode             (item.mode),
        .ack_flag         (item.ack_flag),
        .peer_buffer_used (item.peer_buffer_used),
        .nxt              (state_next),
        .res              (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.cwnd       <= 32'd1;
            state_reg.rwnd       <= '0;
            state_reg.remaining  <= '0;
            state_reg.round_left <= '0;
            state_reg.next_seq   <= 32'd1;
            state_reg.next_ack   <= '0;
            state_reg.segs_sent  <= '0;
            state_reg.acks_seen  <= '0;
            state_reg.phase      <= tssw_pkg::PH_IDLE;
            state_reg.avoidance  <= 1'b0;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
            end
            if (take)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid                   = res_valid_reg;
    assign result.status                  = res_reg.status;
    assign result.seq_number              = res_reg.seq_number;
    assign result.ack_number              = res_reg.ack_number;
    assign result.segment_bytes           = res_reg.segment_bytes;
    assign result.in_congestion_avoidance = res_reg.in_congestion_avoidance;
    assign result.congestion_window       = res_reg.congestion_window;
    assign result.receive_window          = $signed(res_reg.receive_window);

    a_take_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        take |=> result.valid
    ) else $error("accepted transaction produced no result");

    a_segment_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == tssw_pkg::ST_SEGMENT)) |-> (result.segment_bytes != '0)
    ) else $error("emitted segment has zero length");

    a_no_bytes_without_segment: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != tssw_pkg::ST_SEGMENT)) |-> (result.segment_bytes == '0)
    ) else $error("segment length reported without a segment");

    a_cwnd_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg.cwnd != '0
    ) else $error("congestion window dropped to zero");

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tssw_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int MAX_REPORTED = 10;

    typedef struct {
        bit          is_cfg;
        reg_idx_t    idx;
        logic [31:0] value;
        logic [1:0]  mode;
        logic        ack;
        logic [15:0] used;
        bit          known;
        result_t     want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    tssw_item_if   event_ch();
    tssw_result_if report_ch();

    tcp_slow_start_sender_window_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (event_ch),
        .result  (report_ch)
    );

    cfg_t        reg_shadow;
    logic [31:0] win_cwnd;
    logic [31:0] win_rwnd;
    logic [31:0] win_round_left;
    logic [31:0] win_next_seq;
    logic [31:0] win_next_ack;
    logic [23:0] win_remaining;
    logic [15:0] win_segs_sent;
    logic [15:0] win_acks_seen;
    phase_t      win_phase;
    logic        win_avoid;

    result_t     expected_reports[$];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 15;
    int          recv_idle_pct = 76;
    int          hold_off_len = 0;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("%s", msg);
    endfunction

    function automatic string describe(result_t r);
        return $sformatf("status=%0d seq=%h ack=%h seg=%0d ca=%0b cwnd=%h rwnd=%h",
                         r.status, r.seq_number, r.ack_number, r.segment_bytes,
                         r.in_congestion_avoidance, r.congestion_window, r.receive_window);
    endfunction

    function automatic logic rwnd_open();
        return win_rwnd != 32'd0 && !win_rwnd[31];
    endfunction

    function automatic logic [31:0] mss_bytes();
        return (reg_shadow.max_segment_bytes == '0) ? 32'd1
                                                    : 32'(reg_shadow.max_segment_bytes);
    endfunction

    function automatic void open_round();
        if (rwnd_open() && win_remaining != '0)
        begin
            win_round_left = (win_cwnd < 32'(win_remaining)) ? win_cwnd : 32'(win_remaining);
            win_segs_sent = '0;
            win_acks_seen = '0;
            win_phase = PH_SEND;
        end
        else
            win_phase = PH_DONE;
    endfunction

    function automatic void grow_window();
        logic [32:0] w;
        if (!win_avoid)
        begin
            w = {1'b0, win_cwnd} << 1;
            win_cwnd = w[32] ? 32'hFFFF_FFFF : w[31:0];
            if (win_cwnd >= 32'(reg_shadow.slow_start_threshold))
                win_avoid = 1'b1;
        end
        else
        begin
            w = {1'b0, win_cwnd} + {1'b0, mss_bytes()};
            win_cwnd = w[32] ? 32'hFFFF_FFFF : w[31:0];
        end
    endfunction

    function automatic result_t advance_window(logic [1:0] mode, logic ack, logic [15:0] used);
        result_t     r;
        logic [31:0] seg;
        logic        emitted;
        r = '0;
        seg = '0;
        emitted = 1'b0;
        case (mode)
            MODE_START:
            begin
                win_cwnd = 32'd1;
                win_rwnd = 32'(reg_shadow.receiver_buffer_bytes);
                win_next_seq = 32'd1;
                win_next_ack = reg_shadow.initial_ack_number;
                win_remaining = reg_shadow.file_bytes;
                win_avoid = 1'b0;
                open_round();
            end
            MODE_REQUEST:
            begin
                if (win_phase == PH_SEND)
                begin
                    seg = (win_round_left < mss_bytes()) ? win_round_left : mss_bytes();
                    r.seq_number = win_next_seq;
                    r.ack_number = win_next_ack;
                    emitted = 1'b1;
                    win_next_seq = win_next_seq + seg;
                    win_next_ack = win_next_ack + 32'd1;
                    win_remaining = win_remaining - seg[23:0];
                    win_round_left = win_round_left - seg;
                    win_rwnd = win_rwnd - seg;
                    win_segs_sent = win_segs_sent + 16'd1;
                    if (!rwnd_open() || win_round_left == 32'd0)
                        win_phase = PH_WAIT;
                end
            end
            MODE_PACKET:
            begin
                if (win_phase == PH_WAIT && ack)
                begin
                    win_rwnd = 32'(reg_shadow.receiver_buffer_bytes) - 32'(used);
                    win_acks_seen = win_acks_seen + 16'd1;
                    if (win_acks_seen == win_segs_sent)
                    begin
                        grow_window();
                        open_round();
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (emitted)
            r.status = ST_SEGMENT;
        else if (win_phase == PH_IDLE)
            r.status = ST_IDLE;
        else if (win_phase == PH_DONE)
        begin
            r.status = ST_DONE;
            r.seq_number = win_next_seq;
            r.ack_number = win_next_ack + 32'd1;
        end
        else
        begin
            r.status = ST_WAITING;
            r.seq_number = win_next_seq;
            r.ack_number = win_next_ack;
        end
        r.segment_bytes = seg[12:0];
        r.in_congestion_avoidance = win_avoid;
        r.congestion_window = win_cwnd;
        r.receive_window = win_rwnd;
        return r;
    endfunction

    function automatic logic [31:0] shadow_reg(reg_idx_t idx);
        case (idx)
            REG_FILE_BYTES: return 32'(reg_shadow.file_bytes);
            REG_RCV_BUFFER: return 32'(reg_shadow.receiver_buffer_bytes);
            REG_MSS:        return 32'(reg_shadow.max_segment_bytes);
            REG_SSTHRESH:   return 32'(reg_shadow.slow_start_threshold);
            default:        return reg_shadow.initial_ack_number;
        endcase
    endfunction

    function automatic result_t report_of(status_t st, logic [31:0] seq, logic [31:0] ackn,
                                          logic [12:0] seg, logic avoid, logic [31:0] cwnd,
                                          logic [31:0] rwnd);
        result_t r;
        r.status = st;
        r.seq_number = seq;
        r.ack_number = ackn;
        r.segment_bytes = seg;
        r.in_congestion_avoidance = avoid;
        r.congestion_window = cwnd;
        r.receive_window = rwnd;
        return r;
    endfunction

    function automatic void add_cfg(reg_idx_t idx, logic [31:0] value);
        plan_row_t row;
        row = '{idx: REG_FILE_BYTES, default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.value = value;
        plan.push_back(row);
    endfunction

    function automatic void add_event(logic [1:0] mode, logic ack, logic [15:0] used);
        plan_row_t row;
        row = '{idx: REG_FILE_BYTES, default: '0};
        row.mode = mode;
        row.ack = ack;
        row.used = used;
        plan.push_back(row);
    endfunction

    function automatic void add_known(logic [1:0] mode, logic ack, logic [15:0] used,
                                      result_t want);
        plan_row_t row;
        row = '{idx: REG_FILE_BYTES, default: '0};
        row.mode = mode;
        row.ack = ack;
        row.used = used;
        row.known = 1'b1;
        row.want = want;
        plan.push_back(row);
    endfunction

    task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] data,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            REG_FILE_BYTES: reg_shadow.file_bytes = value[23:0];
            REG_RCV_BUFFER: reg_shadow.receiver_buffer_bytes = value[15:0];
            REG_MSS:        reg_shadow.max_segment_bytes = value[12:0];
            REG_SSTHRESH:   reg_shadow.slow_start_threshold = value[23:0];
            default:        reg_shadow.initial_ack_number = value;
        endcase
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd !== shadow_reg(idx))
            note_failure($sformatf("register %s read %h, expected %h",
                                   idx.name(), rd, shadow_reg(idx)));
    endtask

    task automatic wait_for_reports();
        event_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic offer(input logic [1:0] mode, input logic ack, input logic [15:0] used,
                         input bit known, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            event_ch.valid <= 1'b0;
            @(posedge clk);
        end
        event_ch.valid <= 1'b1;
        event_ch.mode <= mode;
        event_ch.ack_flag <= ack;
        event_ch.peer_buffer_used <= used;
        @(posedge clk);
        while (!event_ch.ready)
            @(posedge clk);
        predicted = advance_window(mode, ack, used);
        expected_reports.push_back(known ? want : predicted);
    endtask

    initial
    begin
        report_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                report_ch.ready <= 1'b0;
                hold_off_len = hold_off_len - 1;
            end
            else
                report_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : report_check
        result_t want;
        result_t got;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            got.status = status_t'(report_ch.status);
            got.seq_number = report_ch.seq_number;
            got.ack_number = report_ch.ack_number;
            got.segment_bytes = report_ch.segment_bytes;
            got.in_congestion_avoidance = report_ch.in_congestion_avoidance;
            got.congestion_window = report_ch.congestion_window;
            got.receive_window = report_ch.receive_window;
            if (expected_reports.size() == 0)
                note_failure($sformatf("unexpected report: %s", describe(got)));
            else
            begin
                want = expected_reports.pop_front();
                if (got.status !== want.status
                    || got.seq_number !== want.seq_number
                    || got.ack_number !== want.ack_number
                    || got.segment_bytes !== want.segment_bytes
                    || got.in_congestion_avoidance !== want.in_congestion_avoidance
                    || got.congestion_window !== want.congestion_window
                    || got.receive_window !== want.receive_window)
                    note_failure($sformatf("report mismatch: expected %s, got %s",
                                           describe(want), describe(got)));
            end
        end
    end

    initial
    begin
        logic [1:0]  mode;
        logic        ack;
        logic [15:0] used;
        logic [31:0] value;
        int          session_end;
        result_t     none;

        none = '0;
        session_end = 0;

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        event_ch.valid <= 1'b0;
        event_ch.mode <= '0;
        event_ch.ack_flag <= 1'b0;
        event_ch.peer_buffer_used <= '0;

        reg_shadow.file_bytes = 24'd1;
        reg_shadow.receiver_buffer_bytes = 16'd1;
        reg_shadow.max_segment_bytes = 13'd1;
        reg_shadow.slow_start_threshold = 24'd1;
        reg_shadow.initial_ack_number = 32'd0;
        win_cwnd = 32'd1;
        win_rwnd = '0;
        win_round_left = '0;
        win_next_seq = 32'd1;
        win_next_ack = '0;
        win_remaining = '0;
        win_segs_sent = '0;
        win_acks_seen = '0;
        win_phase = PH_IDLE;
        win_avoid = 1'b0;

        // idle block, then a one-byte file with default registers
        add_known(MODE_REQUEST, 1'b0, 16'h0000,
                  report_of(ST_IDLE, 32'd0, 32'd0, 13'd0, 1'b0, 32'd1, 32'd0));
        add_known(MODE_PACKET, 1'b1, 16'hFFFF,
                  report_of(ST_IDLE, 32'd0, 32'd0, 13'd0, 1'b0, 32'd1, 32'd0));
        add_known(MODE_NOP, 1'b1, 16'hA5A5,
                  report_of(ST_IDLE, 32'd0, 32'd0, 13'd0, 1'b0, 32'd1, 32'd0));
        add_known(MODE_START, 1'b0, 16'h0000,
                  report_of(ST_WAITING, 32'd1, 32'd0, 13'd0, 1'b0, 32'd1, 32'd1));
        add_known(MODE_REQUEST, 1'b0, 16'h0000,
                  report_of(ST_SEGMENT, 32'd1, 32'd0, 13'd1, 1'b0, 32'd1, 32'd0));
        add_known(MODE_REQUEST, 1'b0, 16'h0000,
                  report_of(ST_WAITING, 32'd2, 32'd1, 13'd0, 1'b0, 32'd1, 32'd0));
        add_known(MODE_PACKET, 1'b0, 16'h0000,
                  report_of(ST_WAITING, 32'd2, 32'd1, 13'd0, 1'b0, 32'd1, 32'd0));
        add_known(MODE_PACKET, 1'b1, 16'h0000,
                  report_of(ST_DONE, 32'd2, 32'd2, 13'd0, 1'b1, 32'd2, 32'd1));
        add_known(MODE_REQUEST, 1'b1, 16'h5A5A,
                  report_of(ST_DONE, 32'd2, 32'd2, 13'd0, 1'b1, 32'd2, 32'd1));

        // largest registers but MSS 4096, ack number wraps
        add_cfg(REG_FILE_BYTES, 32'h00FF_FFFF);
        add_cfg(REG_RCV_BUFFER, 32'h0000_FFFF);
        add_cfg(REG_MSS, 32'd4096);
        add_cfg(REG_SSTHRESH, 32'h00FF_FFFF);
        add_cfg(REG_INIT_ACK, 32'hFFFF_FFFF);
        add_known(MODE_START, 1'b0, 16'h0000,
                  report_of(ST_WAITING, 32'd1, 32'hFFFF_FFFF, 13'd0, 1'b0, 32'd1, 32'd65535));
        add_known(MODE_REQUEST, 1'b0, 16'h0000,
                  report_of(ST_SEGMENT, 32'd1, 32'hFFFF_FFFF, 13'd1, 1'b0, 32'd1, 32'd65534));
        add_known(MODE_PACKET, 1'b1, 16'hFFFF,
                  report_of(ST_DONE, 32'd2, 32'd1, 13'd0, 1'b0, 32'd2, 32'd0));
        add_event(MODE_START, 1'b0, 16'h0000);
        add_event(MODE_REQUEST, 1'b0, 16'h0000);
        add_event(MODE_PACKET, 1'b1, 16'h0000);
        add_event(MODE_REQUEST, 1'b0, 16'h0000);
        add_event(MODE_START, 1'b1, 16'h0000);

        // zero MSS and zero threshold
        add_cfg(REG_MSS, 32'd0);
        add_cfg(REG_SSTHRESH, 32'd0);
        add_event(MODE_START, 1'b0, 16'h0000);
        add_event(MODE_REQUEST, 1'b0, 16'h0000);
        add_event(MODE_PACKET, 1'b1, 16'h0000);
        add_event(MODE_REQUEST, 1'b0, 16'h0000);
        add_event(MODE_REQUEST, 1'b0, 16'h0000);
        add_event(MODE_PACKET, 1'b1, 16'h0002);
        add_event(MODE_PACKET, 1'b1, 16'h0003);

        // empty file, then empty receiver buffer
        add_cfg(REG_FILE_BYTES, 32'd0);
        add_known(MODE_START, 1'b0, 16'h0000,
                  report_of(ST_DONE, 32'd1, 32'd0, 13'd0, 1'b0, 32'd1, 32'd65535));
        add_cfg(REG_FILE_BYTES, 32'd5);
        add_cfg(REG_RCV_BUFFER, 32'd0);
        add_known(MODE_START, 1'b0, 16'h0000,
                  report_of(ST_DONE, 32'd1, 32'd0, 13'd0, 1'b0, 32'd1, 32'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_for_reports();
                cfg_write(plan[i].idx, plan[i].value);
            end
            else
                offer(plan[i].mode, plan[i].ack, plan[i].used, plan[i].known, plan[i].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 76;
            end
            else if (n < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (n == session_end)
            begin
                wait_for_reports();
                case ($urandom_range(9))
                    0:       value = 32'h00FF_FFFF;
                    1:       value = 32'd0;
                    2:       value = $urandom_range(1, 16);
                    default: value = $urandom_range(1, 200000);
                endcase
                cfg_write(REG_FILE_BYTES, value);
                case ($urandom_range(9))
                    0:       value = 32'd65535;
                    1:       value = 32'd0;
                    2:       value = $urandom_range(1, 100);
                    default: value = $urandom_range(1000, 65535);
                endcase
                cfg_write(REG_RCV_BUFFER, value);
                case ($urandom_range(11))
                    0:       value = 32'd0;
                    1:       value = 32'd8191;
                    2:       value = 32'd4096;
                    default: value = $urandom_range(1, 1500);
                endcase
                cfg_write(REG_MSS, value);
                case ($urandom_range(9))
                    0:       value = 32'h00FF_FFFF;
                    1:       value = 32'd0;
                    default: value = $urandom_range(1, 65536);
                endcase
                cfg_write(REG_SSTHRESH, value);
                value = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 : $urandom;
                cfg_write(REG_INIT_ACK, value);
                session_end = n + $urandom_range(60, 160);
            end

            if (n == 400 || n == 1300)
                hold_off_len = HOLD_OFF_CYCLES;

            if ($urandom_range(99) < 7)
            begin
                mode = 2'($urandom_range(0, 3));
                ack = 1'($urandom_range(0, 1));
                used = 16'($urandom_range(0, 65535));
            end
            else
            begin
                ack = 1'b1;
                used = '0;
                case (win_phase)
                    PH_SEND: mode = MODE_REQUEST;
                    PH_WAIT:
                    begin
                        mode = MODE_PACKET;
                        if ($urandom_range(9) == 0)
                            used = 16'($urandom_range(0, 65535));
                        else
                            used = 16'($urandom_range(0,
                                                      reg_shadow.receiver_buffer_bytes / 2));
                    end
                    default: mode = MODE_START;
                endcase
            end
            offer(mode, ack, used, 1'b0, none);
        end

        wait_for_reports();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tssw_pkg.sv
sv/tssw_item_if.sv
sv/tssw_result_if.sv
sv/tssw_step.sv
sv/tcp_slow_start_sender_window_core.sv
sim/testbench.sv
